@@ hw/rtl/pbrf_pkg.sv @@
// Shared types and constants of the pixel buffer with rotate and fill.
`default_nettype none
package pbrf_pkg;

  // Operation codes carried on the func field.
  typedef enum logic [3:0] {
    FN_READ       = 4'd0,
    FN_WRITE      = 4'd1,
    FN_FILL_ALL   = 4'd2,
    FN_FILL_RANGE = 4'd3,
    FN_ROT_RANGE  = 4'd4,
    FN_ROT_DOWN   = 4'd5,
    FN_ROT_UP     = 4'd6,
    FN_ROWS_LEFT  = 4'd7,
    FN_ROWS_RIGHT = 4'd8,
    FN_SCROLL_UP  = 4'd9,
    FN_SCROLL_DN  = 4'd10
  } func_t;

  // Configuration register indexes.
  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  // Field and datapath widths fixed by the interface.
  localparam int CountW    = 11;
  localparam int IndexW    = 16;
  localparam int ColorW    = 24;
  localparam int WideW     = 22;  // row base plus column count
  localparam int DividendW = 27;  // amount times column count
  localparam int DivCntW   = 5;

endpackage
`default_nettype wire

@@ hw/rtl/pixel_buffer_rotate_fill.sv @@
// Pixel buffer: one shared copy and remainder unit under a small sequencer.
// Read and write access a single pixel; fills write the range one pixel at a time.
// Rotations reduce the amount with the remainder unit, then copy the range into the
// scratch memory in rotated order and write it back, each pixel read and written in turn.
// Row rotations repeat that per row. After reset a clearing pass writes zero to
// all MAX_PIXELS entries, one a cycle, before the first transaction is taken.
`default_nettype none
module pixel_buffer_rotate_fill #(
  parameter int MAX_PIXELS = 1024,
  parameter int PIXEL_BITS = 24
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input transactions
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3:0]                    func,
  input  wire logic [pbrf_pkg::IndexW-1:0]   first_index,
  input  wire logic [pbrf_pkg::IndexW-1:0]   second_index,
  input  wire logic [9:0]                    row,
  input  wire logic [9:0]                    column,
  input  wire logic [pbrf_pkg::IndexW-1:0]   amount,
  input  wire logic [pbrf_pkg::ColorW-1:0]   color,
  // result transactions
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [pbrf_pkg::ColorW-1:0]        pixel_value,
  output logic                               out_of_range,
  // configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [2:0]                    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import pbrf_pkg::*;

  localparam int AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SW  = $clog2(MAX_PIXELS + 1);
  localparam int DVW = (SW > CountW) ? SW : CountW;
  localparam logic [SW-1:0] MaxSize = SW'(MAX_PIXELS);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_ACCESS, S_RDWAIT, S_FILL, S_ROW, S_NEXTROW,
    S_CLAMP, S_DIV, S_SHIFT, S_CP_RD, S_CP_WR, S_BK_RD, S_BK_WR, S_FINISH
  } state_t;

  state_t state;

  // Configuration and derived size
  logic [CountW-1:0] row_count, column_count;
  logic [SW-1:0]     size;
  logic [2*CountW-1:0] size_full;

  // Captured transaction
  func_t                func_q;
  logic [IndexW-1:0]    first_q, second_q, amount_q;
  logic [9:0]           row_q, col_q;
  logic [PIXEL_BITS-1:0] color_q;

  // Sequencer registers
  logic [WideW-1:0]     idx, from_v, to_v, rbase, hi;
  logic [CountW-1:0]    rcount;
  logic [DividendW-1:0] dividend;
  logic [DVW-1:0]       divisor, rem;
  logic [DivCntW-1:0]   dcnt;
  logic                 div_rows, rows_mode, rev;
  logic [SW-1:0]        base, n, i, j, ccount;
  logic [IndexW:0]      fi;

  // Memory ports
  logic                  mem_we, scr_we;
  logic [AW-1:0]         mem_waddr, mem_raddr, scr_addr;
  logic [PIXEL_BITS-1:0] mem_wdata, mem_rdata, scr_rdata;
  logic [PIXEL_BITS-1:0] store [MAX_PIXELS];
  logic [PIXEL_BITS-1:0] scratch [MAX_PIXELS];

  // Combinational helpers
  logic [WideW-1:0] size_w, fc, tc;
  logic [DVW:0]     trial;

  assign pready   = 1'b1;
  assign in_ready = (state == S_IDLE) && !out_valid;
  assign prdata   = (paddr[2] == REG_COLUMN_COUNT) ? 32'(column_count) : 32'(row_count);

  assign size_full = row_count * column_count;
  assign size_w    = WideW'(size);
  assign fc        = (from_v >= size_w) ? size_w - 1'b1 : from_v;
  assign tc        = (to_v   >= size_w) ? size_w - 1'b1 : to_v;
  assign trial     = {rem, dividend[dcnt]};

  // Configuration writes and the registered store size.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CountW'(1);
      column_count <= CountW'(1);
      size         <= SW'(1);
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_ROW_COUNT) begin
          row_count <= pwdata[CountW-1:0];
        end else begin
          column_count <= pwdata[CountW-1:0];
        end
      end
      size <= (size_full > (2*CountW)'(MAX_PIXELS)) ? MaxSize : SW'(size_full);
    end
  end

  // Memory port control, chosen by the sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(i);
    mem_wdata = color_q;
    mem_raddr = AW'(base + j);
    scr_we    = 1'b0;
    scr_addr  = AW'(i);
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(ccount);
        mem_wdata = '0;
      end
      S_ACCESS: begin
        mem_raddr = AW'(idx);
        mem_waddr = AW'(idx);
        mem_we    = (func_q == FN_WRITE) && (idx < size_w);
      end
      S_FILL: begin
        mem_waddr = AW'(fi);
        mem_we    = (WideW'(fi) < size_w) && (WideW'(fi) <= hi);
      end
      S_CP_WR: scr_we = 1'b1;
      S_BK_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(base + i);
        mem_wdata = scr_rdata;
      end
      default: ;
    endcase
  end

  // Pixel memory: one write and one registered read a cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= store[mem_raddr];
  end

  // Scratch memory holding the rotated copy of a range.
  always_ff @(posedge clk) begin
    if (scr_we) begin
      scratch[scr_addr] <= mem_rdata;
    end
    scr_rdata <= scratch[scr_addr];
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      ccount    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          if (ccount == MaxSize - 1'b1) begin
            state <= S_IDLE;
          end
          ccount <= ccount + 1'b1;
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            func_q       <= func_t'(func);
            first_q      <= first_index;
            second_q     <= second_index;
            row_q        <= row;
            col_q        <= column;
            amount_q     <= amount;
            color_q      <= PIXEL_BITS'(color);
            pixel_value  <= '0;
            out_of_range <= 1'b0;
            rows_mode    <= 1'b0;
            div_rows     <= 1'b0;
            state        <= S_DECODE;
          end
        end
        S_DECODE: begin
          idx <= WideW'(row_q * column_count) + WideW'(col_q);
          rem <= '0;
          dcnt <= DivCntW'(DividendW - 1);
          case (func_q)
            FN_READ, FN_WRITE: state <= S_ACCESS;
            FN_FILL_ALL: begin
              fi    <= '0;
              hi    <= '1;
              state <= S_FILL;
            end
            FN_FILL_RANGE: begin
              fi    <= (first_q < second_q) ? {1'b0, first_q} : {1'b0, second_q};
              hi    <= (first_q < second_q) ? WideW'(second_q) : WideW'(first_q);
              state <= S_FILL;
            end
            FN_ROT_RANGE: begin
              from_v   <= WideW'(first_q);
              to_v     <= WideW'(second_q);
              dividend <= DividendW'(amount_q);
              state    <= S_CLAMP;
            end
            FN_ROT_DOWN, FN_ROT_UP: begin
              from_v   <= (func_q == FN_ROT_DOWN) ? size_w - 1'b1 : '0;
              to_v     <= (func_q == FN_ROT_DOWN) ? '0 : size_w - 1'b1;
              dividend <= DividendW'(amount_q);
              state    <= (size > SW'(1)) ? S_CLAMP : S_FINISH;
            end
            FN_ROWS_LEFT, FN_ROWS_RIGHT: begin
              dividend <= DividendW'(amount_q);
              divisor  <= DVW'(column_count);
              div_rows <= 1'b1;
              state    <= (row_count != '0 && column_count > CountW'(1)) ? S_DIV : S_FINISH;
            end
            FN_SCROLL_UP, FN_SCROLL_DN: begin
              from_v   <= (func_q == FN_SCROLL_UP) ? size_w - 1'b1 : '0;
              to_v     <= (func_q == FN_SCROLL_UP) ? '0 : size_w - 1'b1;
              dividend <= DividendW'(amount_q * column_count);
              state    <= (row_count > CountW'(1) && column_count != '0 && size != '0)
                          ? S_CLAMP : S_FINISH;
            end
            default: state <= S_FINISH;
          endcase
        end
        // Single pixel access; the registered read data arrives in the next cycle.
        S_ACCESS: begin
          if (idx >= size_w) begin
            out_of_range <= 1'b1;
            state        <= S_FINISH;
          end else begin
            state <= (func_q == FN_READ) ? S_RDWAIT : S_FINISH;
          end
        end
        S_RDWAIT: begin
          pixel_value <= ColorW'(mem_rdata);
          state       <= S_FINISH;
        end
        S_FILL: begin
          if ((WideW'(fi) < size_w) && (WideW'(fi) <= hi)) begin
            fi <= fi + 1'b1;
          end else begin
            state <= S_FINISH;
          end
        end
        // Row loop: each row rotates by the reduced count.
        S_ROW: begin
          if (rcount == row_count) begin
            state <= S_FINISH;
          end else begin
            from_v <= (func_q == FN_ROWS_LEFT) ? rbase + WideW'(column_count) - 1'b1 : rbase;
            to_v   <= (func_q == FN_ROWS_LEFT) ? rbase : rbase + WideW'(column_count) - 1'b1;
            state  <= S_CLAMP;
          end
        end
        S_NEXTROW: begin
          rbase  <= rbase + WideW'(column_count);
          rcount <= rcount + 1'b1;
          state  <= S_ROW;
        end
        // Clamp both ends and pick the direction of the rotation.
        S_CLAMP: begin
          rem  <= '0;
          dcnt <= DivCntW'(DividendW - 1);
          if (size == '0 || fc == tc) begin
            state <= rows_mode ? S_NEXTROW : S_FINISH;
          end else if (fc > tc) begin
            base    <= SW'(tc);
            n       <= SW'(fc - tc + 1'b1);
            divisor <= DVW'(fc - tc + 1'b1);
            rev     <= 1'b0;
            state   <= S_DIV;
          end else begin
            base    <= SW'(fc);
            n       <= SW'(tc - fc + 1'b1);
            divisor <= DVW'(tc - fc + 1'b1);
            rev     <= 1'b1;
            state   <= S_DIV;
          end
        end
        // Restoring remainder, one dividend bit a cycle.
        S_DIV: begin
          if (trial >= {1'b0, divisor}) begin
            rem <= DVW'(trial - {1'b0, divisor});
          end else begin
            rem <= trial[DVW-1:0];
          end
          dcnt <= dcnt - 1'b1;
          if (dcnt == '0) begin
            state <= div_rows ? S_ROW : S_SHIFT;
          end
          if (dcnt == '0 && div_rows) begin
            dividend  <= DividendW'((trial >= {1'b0, divisor})
                         ? DVW'(trial - {1'b0, divisor}) : trial[DVW-1:0]);
            div_rows  <= 1'b0;
            rows_mode <= 1'b1;
            rbase     <= '0;
            rcount    <= '0;
          end
        end
        S_SHIFT: begin
          if (rev) begin
            j <= (rem == '0) ? '0 : SW'(DVW'(n) - rem);
          end else begin
            j <= SW'(rem);
          end
          i     <= '0;
          state <= S_CP_RD;
        end
        // Copy the range into scratch in rotated order.
        S_CP_RD: state <= S_CP_WR;
        S_CP_WR: begin
          if (i == n - 1'b1) begin
            i     <= '0;
            state <= S_BK_RD;
          end else begin
            i     <= i + 1'b1;
            j     <= (j == n - 1'b1) ? '0 : j + 1'b1;
            state <= S_CP_RD;
          end
        end
        // Write the scratch copy back in place.
        S_BK_RD: state <= S_BK_WR;
        S_BK_WR: begin
          if (i == n - 1'b1) begin
            state <= rows_mode ? S_NEXTROW : S_FINISH;
          end else begin
            i     <= i + 1'b1;
            state <= S_BK_RD;
          end
        end
        S_FINISH: begin
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new transaction is never taken while a result waits.
  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("transaction taken while result pending");

  // Nothing is accepted during the clearing pass.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !in_ready) else $error("ready during clearing pass");

  // Operations only write inside the active size.
  a_write_in_size: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state != S_CLEAR) |-> (WideW'(mem_waddr) < size_w))
    else $error("pixel write past active size");

  // The remainder unit never runs with a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> divisor != '0) else $error("remainder by zero");

endmodule
`default_nettype wire
